[rtl/core/thi_pkg.sv]
package thi_pkg;

  localparam int W = 32;
  localparam int NCOMP = 6;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_TRIM_RD,
    ST_TRIM_WT,
    ST_TRIM_CHK,
    ST_SCAN_RD,
    ST_SCAN_WT,
    ST_SCAN_CHK,
    ST_PAIR_RD,
    ST_PAIR_WT,
    ST_DIV,
    ST_DONE
  } state_t;

  // one stored entry
  typedef struct packed {
    logic [W-1:0] stamp;
    logic [W-1:0] pos_x;
    logic [W-1:0] pos_y;
    logic [W-1:0] pos_z;
    logic [W-1:0] vel_x;
    logic [W-1:0] vel_y;
    logic [W-1:0] vel_z;
    logic [W-1:0] heading;
  } entry_t;

  // control from sequencer into the divider cell row
  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

endpackage

[rtl/core/thi_ram.sv]
module thi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/thi_cell.sv]
// One cell of the divider row: restoring divide of |b - a| * num by den, one
// quotient bit a step, then add the quotient to a or subtract it from a.
// The control is registered and handed to the next cell, so each cell acts
// in the cycle after its neighbour.
module thi_cell
  import thi_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  div_ctl_t      ctl,
  input  logic [W-1:0]  a,
  input  logic [W-1:0]  b,
  input  logic [W-1:0]  num,
  input  logic [W-1:0]  den,
  output div_ctl_t      ctl_out,
  output logic [W-1:0]  res
);

  localparam int PW = 2 * W + 1;

  logic [PW-1:0] prod_r, prod_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [W-1:0]  base_r;
  logic          neg_r;
  div_ctl_t      ctl_r;
  logic [W:0]    diff;
  logic [W:0]    mag;
  logic [W+1:0]  trial;

  assign diff = {b[W-1], b} - {a[W-1], a};
  assign mag  = diff[W] ? (~diff + 1'b1) : diff;
  assign trial = {rem_r, prod_r[PW-1]} - {2'b00, den};

  // load dividend then shift one bit a step
  always_comb begin
    prod_nxt = prod_r;
    rem_nxt  = rem_r;
    if (ctl.load) begin
      prod_nxt = PW'(mag) * PW'(num);
      rem_nxt  = '0;
    end else if (ctl.step) begin
      if (!trial[W+1]) begin
        rem_nxt = trial[W:0];
      end else begin
        rem_nxt = {rem_r[W-1:0], prod_r[PW-1]};
      end
      prod_nxt = {prod_r[PW-2:0], ~trial[W+1]};
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    if (ctl.load) begin
      base_r <= a;
      neg_r  <= diff[W];
    end
  end

  // hand the control on to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  assign ctl_out = ctl_r;
  assign res = neg_r ? (base_r - prod_r[W-1:0]) : (base_r + prod_r[W-1:0]);

endmodule

[rtl/core/timestamped_history_interpolator.sv]
// History ring of up to DEPTH timestamped entries (position, velocity and
// heading) in one block RAM. A query returns the first entry whose stamp
// matches, or else a linear blend of the two entries that bracket the stamp
// (heading taken from the earlier one), worked out in a row of six divider cells. One request is handled at a time.
// A record writes the entry and then drops old entries from the oldest end,
// one at a time. A query reads every stored entry through the single RAM
// read port, and the done state then loads the result register; an
// interpolated query also fetches the bracketing pair and runs the divider
// row (fetch, load, 65 quotient bits over the 65-bit product, and the control
// rippling down the row). For a full ring of 128 entries the scan sets most
// of the latency. Clear and the unused opcode are handled in the idle state
// and give no result. A query that ends while an earlier result still waits
// on out_tready holds the block until that result is taken.
module timestamped_history_interpolator
  import thi_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode, stamp, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, heading
  input  logic [263:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // found, in_history, oldest_age, out_stamp, out_pos_x..z, out_vel_x..z,
  // out_heading
  output logic [295:0] out_tdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = $bits(entry_t);
  localparam int DSTEPS = 2 * W + 1;
  localparam int DLAST = DSTEPS + NCOMP;
  localparam int DCW = $clog2(DLAST + 1);

  state_t        st_r, st_nxt;
  logic [W-1:0]  window_r;
  logic [AW-1:0] oldest_r, oldest_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [W-1:0]  t_r;
  entry_t        new_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] bslot_r, bslot_nxt, aslot_r, aslot_nxt;
  logic          hb_r, hb_nxt, ha_r, ha_nxt, hx_r, hx_nxt;
  entry_t        before_r, before_nxt;
  entry_t        after_r;
  logic [W-1:0]  ostamp_r, ostamp_nxt, nstamp_r, nstamp_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic          ovalid_r;
  logic [295:0]  odata_r;
  logic          load_out;
  logic [295:0]  fin;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        rdata;
  div_ctl_t      dctl;
  div_ctl_t      link [NCOMP];
  logic [W-1:0]  num, den;
  logic [W-1:0]  lres [NCOMP];

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] o, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = {1'b0, CW'(o)} + {1'b0, i};
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  thi_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(new_r),
    .raddr(raddr), .rdata(rdata)
  );

  assign num = t_r - before_r.stamp;
  assign den = after_r.stamp - before_r.stamp;

  // divider row, control passed from cell to cell
  thi_cell u_c0 (.clk(clk), .rst_n(rst_n), .ctl(dctl),
                 .a(before_r.pos_x), .b(after_r.pos_x), .num(num), .den(den),
                 .ctl_out(link[0]), .res(lres[0]));
  thi_cell u_c1 (.clk(clk), .rst_n(rst_n), .ctl(link[0]),
                 .a(before_r.pos_y), .b(after_r.pos_y), .num(num), .den(den),
                 .ctl_out(link[1]), .res(lres[1]));
  thi_cell u_c2 (.clk(clk), .rst_n(rst_n), .ctl(link[1]),
                 .a(before_r.pos_z), .b(after_r.pos_z), .num(num), .den(den),
                 .ctl_out(link[2]), .res(lres[2]));
  thi_cell u_c3 (.clk(clk), .rst_n(rst_n), .ctl(link[2]),
                 .a(before_r.vel_x), .b(after_r.vel_x), .num(num), .den(den),
                 .ctl_out(link[3]), .res(lres[3]));
  thi_cell u_c4 (.clk(clk), .rst_n(rst_n), .ctl(link[3]),
                 .a(before_r.vel_y), .b(after_r.vel_y), .num(num), .den(den),
                 .ctl_out(link[4]), .res(lres[4]));
  thi_cell u_c5 (.clk(clk), .rst_n(rst_n), .ctl(link[4]),
                 .a(before_r.vel_z), .b(after_r.vel_z), .num(num), .den(den),
                 .ctl_out(link[5]), .res(lres[5]));

  assign cfg_ready  = (st_r == ST_IDLE);
  assign in_tready  = (st_r == ST_IDLE) && !cfg_valid;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  // sequencer
  always_comb begin
    st_nxt     = st_r;
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    bslot_nxt  = bslot_r;
    aslot_nxt  = aslot_r;
    hb_nxt     = hb_r;
    ha_nxt     = ha_r;
    hx_nxt     = hx_r;
    before_nxt = before_r;
    ostamp_nxt = ostamp_r;
    nstamp_nxt = nstamp_r;
    dcnt_nxt   = dcnt_r;
    we         = 1'b0;
    waddr      = slot(oldest_r, count_r);
    raddr      = slot(oldest_r, idx_r);
    dctl       = '0;
    load_out   = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          case (op_t'(in_tdata[1:0]))
            OP_RECORD: st_nxt = ST_WRITE;
            OP_QUERY:  st_nxt = ST_SCAN_RD;
            OP_CLEAR: begin
              count_nxt  = '0;
              oldest_nxt = '0;
            end
            default: ;
          endcase
          idx_nxt = '0;
          hb_nxt  = 1'b0;
          ha_nxt  = 1'b0;
          hx_nxt  = 1'b0;
        end
      end
      ST_WRITE: begin
        we = 1'b1;
        if (count_r == CW'(DEPTH)) begin
          waddr      = oldest_r;
          oldest_nxt = slot(oldest_r, CW'(1));
        end else begin
          count_nxt = count_r + CW'(1);
        end
        st_nxt = ST_TRIM_RD;
      end
      ST_TRIM_RD: begin
        raddr  = oldest_r;
        st_nxt = (count_r == '0) ? ST_IDLE : ST_TRIM_WT;
      end
      ST_TRIM_WT: begin
        raddr  = oldest_r;
        st_nxt = ST_TRIM_CHK;
      end
      ST_TRIM_CHK: begin
        if ((t_r - rdata.stamp) > window_r) begin
          oldest_nxt = slot(oldest_r, CW'(1));
          count_nxt  = count_r - CW'(1);
          st_nxt     = ST_TRIM_RD;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        st_nxt = (count_r == '0) ? ST_DONE : ST_SCAN_WT;
      end
      ST_SCAN_WT: st_nxt = ST_SCAN_CHK;
      // note oldest and newest stamps, first exact hit and the bracketing pair
      ST_SCAN_CHK: begin
        if (idx_r == '0) ostamp_nxt = rdata.stamp;
        nstamp_nxt = rdata.stamp;
        if (rdata.stamp == t_r) begin
          if (!hx_r) begin
            before_nxt = rdata;
            hx_nxt     = 1'b1;
          end
        end else if (!ha_r) begin
          if (rdata.stamp < t_r) begin
            bslot_nxt = raddr;
            hb_nxt    = 1'b1;
          end else begin
            aslot_nxt = raddr;
            ha_nxt    = 1'b1;
          end
        end
        idx_nxt = idx_r + CW'(1);
        if (idx_nxt != count_r) begin
          st_nxt = ST_SCAN_RD;
        end else if (!hx_nxt && hb_nxt && ha_nxt) begin
          st_nxt = ST_PAIR_RD;
        end else begin
          st_nxt = ST_DONE;
        end
      end
      ST_PAIR_RD: begin
        raddr  = bslot_r;
        st_nxt = ST_PAIR_WT;
      end
      ST_PAIR_WT: begin
        raddr      = aslot_r;
        before_nxt = rdata;
        dcnt_nxt   = '0;
        st_nxt     = ST_DIV;
      end
      // fetch, load, step, then let the control reach the last cell
      ST_DIV: begin
        dcnt_nxt = dcnt_r + DCW'(1);
        if (dcnt_r == DCW'(1)) begin
          dctl.load = 1'b1;
        end else if (dcnt_r > DCW'(1) && dcnt_r <= DCW'(DSTEPS + 1)) begin
          dctl.step = 1'b1;
        end
        if (dcnt_r == DCW'(DLAST)) st_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!ovalid_r || out_tready) begin
          load_out = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // assemble the result
  always_comb begin
    fin = '0;
    if (count_r != '0) begin
      fin[1]    = (t_r >= ostamp_r) && (t_r <= nstamp_r);
      fin[33:2] = t_r - ostamp_r;
    end
    if (hx_r || (hb_r && ha_r)) begin
      fin[0]       = 1'b1;
      fin[289:258] = before_r.heading;
      if (!hx_r && (after_r.stamp != before_r.stamp)) begin
        fin[65:34]   = t_r;
        fin[97:66]   = lres[0];
        fin[129:98]  = lres[1];
        fin[161:130] = lres[2];
        fin[193:162] = lres[3];
        fin[225:194] = lres[4];
        fin[257:226] = lres[5];
      end else begin
        fin[65:34]   = before_r.stamp;
        fin[97:66]   = before_r.pos_x;
        fin[129:98]  = before_r.pos_y;
        fin[161:130] = before_r.pos_z;
        fin[193:162] = before_r.vel_x;
        fin[225:194] = before_r.vel_y;
        fin[257:226] = before_r.vel_z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      window_r <= 32'd2000;
      oldest_r <= '0;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
      if (cfg_valid && cfg_ready) window_r <= cfg_data;
      if (load_out) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    bslot_r  <= bslot_nxt;
    aslot_r  <= aslot_nxt;
    hb_r     <= hb_nxt;
    ha_r     <= ha_nxt;
    hx_r     <= hx_nxt;
    before_r <= before_nxt;
    ostamp_r <= ostamp_nxt;
    nstamp_r <= nstamp_nxt;
    dcnt_r   <= dcnt_nxt;
    if (st_r == ST_IDLE && in_tvalid && in_tready) begin
      t_r   <= in_tdata[33:2];
      new_r <= {in_tdata[33:2], in_tdata[65:34], in_tdata[97:66], in_tdata[129:98],
                in_tdata[161:130], in_tdata[193:162], in_tdata[225:194],
                in_tdata[257:226]};
    end
    if (st_r == ST_DIV && dcnt_r == '0) after_r <= rdata;
    if (load_out) odata_r <= fin;
  end

  // a record gives no result in its write state
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_WRITE) |-> !load_out)
    else $error("result on record");
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_tready |=> $stable(odata_r))
    else $error("result changed while held");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> (link[NCOMP-1] == '0))
    else $error("divider row busy while idle");

endmodule

[tb/tb_top.sv]
module tb_top
  import thi_pkg::*;
;

  localparam int HDEPTH = 128;

  // one field set of a result
  typedef struct packed {
    logic        found;
    logic        in_hist;
    logic [31:0] oldest_age;
    logic [31:0] stamp;
    logic [31:0] px, py, pz, vx, vy, vz;
    logic [31:0] heading;
  } fix_t;

  // Scoreboard: history model plus the queue of predicted query results
  class history_board;
    logic [31:0] st[HDEPTH], px[HDEPTH], py[HDEPTH], pz[HDEPTH];
    logic [31:0] vx[HDEPTH], vy[HDEPTH], vz[HDEPTH], hd[HDEPTH];
    int unsigned head, count;
    logic [31:0] window;
    fix_t pending[$];
    int errors;

    function new();
      head = 0; count = 0; window = 32'd2000; errors = 0;
    endfunction

    function int unsigned slot(int unsigned i);
      return (head + i) % HDEPTH;
    endfunction

    // a + trunc((b - a) * num / den), wrapped to 32 bits
    function logic [31:0] blend(logic [31:0] a, logic [31:0] b,
                                logic [31:0] num, logic [31:0] den);
      logic signed [33:0] d;
      logic [32:0] mag;
      logic [64:0] q;
      d = $signed({{2{b[31]}}, b}) - $signed({{2{a[31]}}, a});
      mag = d[33] ? 33'(-d) : d[32:0];
      q = ({32'd0, mag} * {33'd0, num}) / {33'd0, den};
      return d[33] ? a - q[31:0] : a + q[31:0];
    endfunction

    function void take_entry(int unsigned s, ref fix_t r);
      r.found = 1; r.stamp = st[s]; r.px = px[s]; r.py = py[s]; r.pz = pz[s];
      r.vx = vx[s]; r.vy = vy[s]; r.vz = vz[s]; r.heading = hd[s];
    endfunction

    function fix_t lookup(logic [31:0] t);
      fix_t r;
      int unsigned b, a, s;
      bit hb, ha;
      logic [31:0] o, n, num, den;
      r = '0; hb = 0; ha = 0; b = 0; a = 0;
      if (count == 0) return r;
      o = st[slot(0)]; n = st[slot(count - 1)];
      r.in_hist = (t >= o) && (t <= n);
      r.oldest_age = t - o;
      for (int unsigned i = 0; i < count; i++)
        if (st[slot(i)] == t) begin
          take_entry(slot(i), r);
          return r;
        end
      if (count < 2) return r;
      for (int unsigned i = 0; i < count; i++) begin
        s = slot(i);
        if (st[s] <= t) begin
          b = s; hb = 1;
        end else begin
          a = s; ha = 1;
          break;
        end
      end
      if (!hb || !ha) return r;
      den = st[a] - st[b];
      num = t - st[b];
      if (den == 0) begin
        take_entry(b, r);
        return r;
      end
      r.found = 1; r.stamp = t;
      r.px = blend(px[b], px[a], num, den); r.py = blend(py[b], py[a], num, den);
      r.pz = blend(pz[b], pz[a], num, den); r.vx = blend(vx[b], vx[a], num, den);
      r.vy = blend(vy[b], vy[a], num, den); r.vz = blend(vz[b], vz[a], num, den);
      r.heading = hd[b];
      return r;
    endfunction

    // note an accepted request
    function void note_request(logic [263:0] d);
      int unsigned s;
      logic [31:0] t;
      op_t op;
      op = op_t'(d[1:0]);
      t = d[33:2];
      case (op)
        OP_RECORD: begin
          s = (count >= HDEPTH) ? head : slot(count);
          st[s] = t; px[s] = d[65:34]; py[s] = d[97:66]; pz[s] = d[129:98];
          vx[s] = d[161:130]; vy[s] = d[193:162]; vz[s] = d[225:194];
          hd[s] = d[257:226];
          if (count < HDEPTH) count++;
          else head = (head + 1) % HDEPTH;
          while (count > 0 && (t - st[head]) > window) begin
            head = (head + 1) % HDEPTH;
            count--;
          end
        end
        OP_QUERY: pending = {pending, lookup(t)};
        OP_CLEAR: begin
          count = 0; head = 0;
        end
        default: ;
      endcase
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    // check one accepted result
    task check_result(logic [295:0] d);
      fix_t w;
      if (pending.size() == 0) begin
        report("unexpected result", d[31:0], 32'd0);
        return;
      end
      w = pending.pop_front();
      if (d[0] !== w.found) report("found", 32'(d[0]), 32'(w.found));
      if (d[1] !== w.in_hist) report("in_history", 32'(d[1]), 32'(w.in_hist));
      if (d[33:2] !== w.oldest_age) report("oldest_age", d[33:2], w.oldest_age);
      if (d[65:34] !== w.stamp) report("stamp", d[65:34], w.stamp);
      if (d[97:66] !== w.px) report("pos_x", d[97:66], w.px);
      if (d[129:98] !== w.py) report("pos_y", d[129:98], w.py);
      if (d[161:130] !== w.pz) report("pos_z", d[161:130], w.pz);
      if (d[193:162] !== w.vx) report("vel_x", d[193:162], w.vx);
      if (d[225:194] !== w.vy) report("vel_y", d[225:194], w.vy);
      if (d[257:226] !== w.vz) report("vel_z", d[257:226], w.vz);
      if (d[289:258] !== w.heading) report("heading", d[289:258], w.heading);
    endtask
  endclass

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [31:0] cfg_data;
  logic in_tvalid, in_tready;
  logic [263:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [295:0] out_tdata;

  history_board board;
  int send_gap, recv_gap;
  longint cycles;
  logic [31:0] clock_ms;

  timestamped_history_interpolator dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // cycle count and timeout
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 10000000) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // result side: random stall, check on every accepted result
  initial begin
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
      @(negedge clk);
      out_tready = ($urandom_range(99) >= recv_gap);
    end
  end

  // Request packing, first field in the lowest bits
  function automatic logic [263:0] pack(op_t op, logic [31:0] t, logic [31:0] v[7]);
    return {6'd0, v[6], v[5], v[4], v[3], v[2], v[1], v[0], t, op};
  endfunction

  task automatic send(op_t op, logic [31:0] t, logic [31:0] v[7]);
    while ($urandom_range(99) < send_gap) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = pack(op, t, v);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_request(in_tdata);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic record(logic [31:0] t, bit extreme);
    logic [31:0] v[7];
    foreach (v[i]) v[i] = extreme ? ($urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff)
                                  : $urandom;
    send(OP_RECORD, t, v);
  endtask

  task automatic simple(op_t op, logic [31:0] t);
    logic [31:0] v[7];
    foreach (v[i]) v[i] = $urandom;
    send(op, t, v);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_window(logic [31:0] w);
    drain();
    cfg_valid = 1'b1;
    cfg_data = w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.window = w;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // in-order records mixed at random with queries, clears and unused opcodes
  task automatic episode(int n, logic [31:0] step_max);
    logic [31:0] t0;
    t0 = clock_ms;
    repeat (n) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          clock_ms += $urandom_range(step_max);
          record(clock_ms, $urandom_range(15) == 0);
        end
        4, 5, 6: simple(OP_QUERY, t0 + $urandom_range(clock_ms - t0 + 2));
        7: simple(OP_QUERY, $urandom);
        8: simple($urandom_range(20) == 0 ? OP_CLEAR : OP_NONE, $urandom);
        default: simple(OP_QUERY, clock_ms - $urandom_range(3));
      endcase
    end
  endtask

  initial begin
    board = new();
    rst_n = 0; cfg_valid = 0; cfg_data = 0; in_tvalid = 0; in_tdata = '0;
    send_gap = 14; recv_gap = 53; clock_ms = 0;
    repeat (9) @(negedge clk);
    rst_n = 1;

    // directed: empty, single entry, extremes, exact hits and wrap of ages
    simple(OP_QUERY, 32'd5);
    record(32'd100, 1);
    simple(OP_QUERY, 32'd100);
    simple(OP_QUERY, 32'd150);
    record(32'd300, 1);
    record(32'd300, 0);
    simple(OP_QUERY, 32'd200);
    simple(OP_QUERY, 32'd300);
    simple(OP_QUERY, 32'd99);
    simple(OP_QUERY, 32'd301);
    simple(OP_NONE, 32'd1);
    simple(OP_CLEAR, 32'd0);
    simple(OP_QUERY, 32'd100);
    record(32'hffff_fff0, 1);
    record(32'hffff_ffff, 1);
    simple(OP_QUERY, 32'hffff_fff7);
    record(32'd0, 0);
    simple(OP_QUERY, 32'h0000_0000);
    drain();
    simple(OP_CLEAR, 32'd0);

    write_window(32'hffff_ffff);
    clock_ms = 32'd1000;
    episode(650, 40);
    write_window(32'd0);
    episode(60, 3);
    send_gap = 53; recv_gap = 14;
    write_window(32'd150);
    episode(600, 20);
    send_gap = 0; recv_gap = 0;
    write_window(32'd2000);
    clock_ms = 32'hffff_f000;
    episode(640, 60);

    drain();
    repeat (300) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
